>>> rtl/fpts_pkg.sv
// Shared types and codes for the frequency/phase tick scheduler.
package fpts_pkg;

    // Input item kinds.
    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_TICK   = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // Result kinds.
    localparam logic [1:0] RES_ADDED   = 2'd0;
    localparam logic [1:0] RES_FULL    = 2'd1;
    localparam logic [1:0] RES_DUE     = 2'd2;

    // Most results a single tick may report.
    localparam int unsigned RESULT_LIMIT = 16;

    // Command passed from the front end to the back end.
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] period;
        logic [15:0] offset;
        logic [15:0] target_id;
    } t_cmd;

    // One result item.
    typedef struct packed {
        logic [1:0]  result_kind;
        logic [15:0] task_id;
        logic [31:0] tick_now;
        logic        last_of_run;
    } t_result;

endpackage

>>> rtl/fpts_front.sv
// Front end: accepts items, drops unused kinds and queues commands for the back end.
module fpts_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_full,
    input  fpts_pkg::t_cmd i_cmd,
    output logic           o_valid,
    output fpts_pkg::t_cmd o_cmd,
    input  logic           i_take
);
    import fpts_pkg::*;

    localparam int unsigned DEPTH = 4;

    t_cmd       r_mem [DEPTH];
    logic [1:0] r_wr;
    logic [1:0] r_rd;
    logic [2:0] r_cnt;
    logic       w_wr_en;
    logic       w_rd_en;

    // A transfer of an unused kind is consumed without being queued.
    assign o_full  = (r_cnt == 3'(DEPTH));
    assign w_wr_en = i_push && !o_full && (i_cmd.kind != KIND_UNUSED);
    assign o_valid = (r_cnt != 3'd0);
    assign w_rd_en = o_valid && i_take;
    assign o_cmd   = r_mem[r_rd];

    // Command storage.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // Queue pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr_en) r_wr <= r_wr + 2'd1;
            if (w_rd_en) r_rd <= r_rd + 2'd1;
            r_cnt <= r_cnt + 3'(w_wr_en) - 3'(w_rd_en);
        end
    end

endmodule

>>> rtl/fpts_mod.sv
// Iterative 33-bit by 16-bit remainder unit, one quotient bit per cycle.
module fpts_mod (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [32:0] i_dividend,
    input  logic [15:0] i_divisor,
    output logic        o_done,
    output logic        o_zero
);
    logic [32:0] r_num;
    logic [16:0] r_rem;
    logic [15:0] r_div;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [16:0] w_sh;
    logic [16:0] w_sub;

    assign w_sh  = {r_rem[15:0], r_num[32]};
    assign w_sub = w_sh - {1'b0, r_div};

    // Restoring division; the remainder stays below the divisor.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_num  <= i_dividend;
                r_div  <= i_divisor;
                r_rem  <= '0;
                r_cnt  <= 6'd33;
            end else if (r_busy) begin
                r_num <= {r_num[31:0], 1'b0};
                r_rem <= w_sub[16] ? w_sh : w_sub;
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_zero = (r_rem == 17'd0);

endmodule

>>> rtl/fpts_back.sv
// Back end: keeps the task table and carries out add, remove and tick commands.
module fpts_back #(
    parameter int unsigned MAX_ENTRIES = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  fpts_pkg::t_cmd      i_cmd,
    output logic                o_take,
    output logic                o_res_valid,
    output fpts_pkg::t_result   o_res,
    input  logic                i_res_take
);
    import fpts_pkg::*;

    localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MOVE  = 6'b000010,
        ST_CHECK = 6'b000100,
        ST_WAIT  = 6'b001000,
        ST_EMIT  = 6'b010000,
        ST_DONE  = 6'b100000
    } t_state;

    logic [15:0] r_period [MAX_ENTRIES];
    logic [15:0] r_offset [MAX_ENTRIES];
    logic [15:0] r_ident  [MAX_ENTRIES];

    t_state      r_state;
    logic [CW-1:0] r_count;
    logic [15:0] r_next_id;
    logic [31:0] r_tick;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_kept;
    logic [15:0] r_target;
    logic [4:0]  r_nres;
    logic        r_start;
    logic        r_hit;
    logic [15:0] r_hit_id;
    logic [1:0]  r_add_kind;
    logic        r_out_v;
    t_result     r_out;

    logic        w_mdone;
    logic        w_mzero;
    logic [IW-1:0] w_i;
    logic [IW-1:0] w_k;
    logic [IW-1:0] w_c;

    assign w_i = r_idx[IW-1:0];
    assign w_k = r_kept[IW-1:0];
    assign w_c = r_count[IW-1:0];

    fpts_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_start),
        .i_dividend ({1'b0, r_tick} + {17'd0, r_offset[w_i]}),
        .i_divisor  (r_period[w_i]),
        .o_done     (w_mdone),
        .o_zero     (w_mzero)
    );

    assign o_take      = (r_state == ST_IDLE) && i_valid;
    assign o_res_valid = r_out_v;
    assign o_res       = r_out;

    // Table storage writes.
    always_ff @(posedge i_clk) begin
        if (o_take && i_cmd.kind == KIND_ADD && r_count < CW'(MAX_ENTRIES)) begin
            r_period[w_c] <= i_cmd.period;
            r_offset[w_c] <= i_cmd.offset;
            r_ident[w_c]  <= r_next_id;
        end else if (r_state == ST_MOVE && r_idx < r_count && r_ident[w_i] != r_target) begin
            r_period[w_k] <= r_period[w_i];
            r_offset[w_k] <= r_offset[w_i];
            r_ident[w_k]  <= r_ident[w_i];
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_next_id <= '0;
            r_tick    <= '0;
            r_out_v   <= 1'b0;
            r_start   <= 1'b0;
            r_idx     <= '0;
            r_kept    <= '0;
            r_nres    <= '0;
            r_hit     <= 1'b0;
        end else begin
            r_start <= 1'b0;
            if (r_out_v && i_res_take) r_out_v <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (o_take) begin
                        r_idx    <= '0;
                        r_kept   <= '0;
                        r_nres   <= '0;
                        r_hit    <= 1'b0;
                        r_target <= i_cmd.target_id;
                        priority if (i_cmd.kind == KIND_ADD) begin
                            // Keep the add result aside until the output register is free.
                            if (r_count < CW'(MAX_ENTRIES)) begin
                                r_add_kind <= RES_ADDED;
                                r_hit_id   <= r_next_id;
                                r_count    <= r_count + CW'(1);
                                r_next_id  <= r_next_id + 16'd1;
                            end else begin
                                r_add_kind <= RES_FULL;
                                r_hit_id   <= '0;
                            end
                            r_state <= ST_EMIT;
                        end else if (i_cmd.kind == KIND_REMOVE) begin
                            r_state <= ST_MOVE;
                        end else begin
                            r_tick  <= r_tick + 32'd1;
                            r_state <= ST_CHECK;
                        end
                    end
                end
                ST_MOVE: begin
                    if (r_idx < r_count) begin
                        if (r_ident[w_i] != r_target) r_kept <= r_kept + CW'(1);
                        r_idx <= r_idx + CW'(1);
                    end else begin
                        r_count <= r_kept;
                        r_state <= ST_IDLE;
                    end
                end
                ST_CHECK: begin
                    // Visit the next entry, or flush the held due entry at the end.
                    if (r_idx < r_count && r_nres < 5'(RESULT_LIMIT)) begin
                        if (r_period[w_i] != 16'd0 && {16'd0, r_period[w_i]} <= r_tick) begin
                            r_start <= 1'b1;
                            r_state <= ST_WAIT;
                        end else begin
                            r_idx <= r_idx + CW'(1);
                        end
                    end else if (r_hit) begin
                        if (!r_out_v || i_res_take) begin
                            r_out_v <= 1'b1;
                            r_out   <= '{RES_DUE, r_hit_id, r_tick, 1'b1};
                            r_hit   <= 1'b0;
                            r_state <= ST_IDLE;
                        end
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_WAIT: begin
                    if (w_mdone) begin
                        if (w_mzero) begin
                            r_state <= ST_DONE;
                        end else begin
                            r_idx   <= r_idx + CW'(1);
                            r_state <= ST_CHECK;
                        end
                    end
                end
                ST_DONE: begin
                    // A new due entry: the one held before it is not the last.
                    if (!r_hit || !r_out_v || i_res_take) begin
                        if (r_hit) begin
                            r_out_v <= 1'b1;
                            r_out   <= '{RES_DUE, r_hit_id, r_tick, 1'b0};
                        end
                        r_hit    <= 1'b1;
                        r_hit_id <= r_ident[w_i];
                        r_nres   <= r_nres + 5'd1;
                        r_idx    <= r_idx + CW'(1);
                        r_state  <= ST_CHECK;
                    end
                end
                ST_EMIT: begin
                    if (!r_out_v || i_res_take) begin
                        r_out_v <= 1'b1;
                        r_out   <= '{r_add_kind, r_hit_id, r_tick, 1'b1};
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

>>> rtl/frequency_phase_tick_scheduler_unit.sv
// Top level of the frequency/phase tick scheduler.
//
// Input channel: an item transfers when i_push is high and o_full is low.
// Kind add stores a task and gives one result with its id (or a full-table
// refusal); kind remove deletes all tasks with the id and gives no result;
// kind tick advances the tick count and reports each due task in table order.
// Result channel: while o_empty is low the oldest result is on the o_ ports,
// and it transfers when i_pop is high.
// A four-entry command queue separates the front end from the table engine.
// An add gives its result through the output register, a remove walks the
// whole table, and a tick walks the table and runs the bit-serial 33-bit
// remainder unit for each entry whose period allows a check.
// Reset clears the table count, the id counter and the tick count; no
// clearing pass is needed. When the receiver stalls, the engine holds its
// result and at most one more, then the command queue fills and o_full rises.
module frequency_phase_tick_scheduler_unit #(
    parameter int unsigned MAX_ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_period,
    input  logic [15:0] i_offset,
    input  logic [15:0] i_target_id,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [1:0]  o_result_kind,
    output logic [15:0] o_task_id,
    output logic [31:0] o_tick_now,
    output logic        o_last_of_run
);
    import fpts_pkg::*;

    t_cmd    w_cmd_in;
    t_cmd    w_cmd;
    logic    w_cmd_valid;
    logic    w_take;
    logic    w_res_valid;
    t_result w_res;

    assign w_cmd_in = '{i_kind, i_period, i_offset, i_target_id};

    fpts_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .o_full  (o_full),
        .i_cmd   (w_cmd_in),
        .o_valid (w_cmd_valid),
        .o_cmd   (w_cmd),
        .i_take  (w_take)
    );

    fpts_back #(.MAX_ENTRIES(MAX_ENTRIES)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_take      (w_take),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_take  (i_pop)
    );

    assign o_empty       = !w_res_valid;
    assign o_result_kind = w_res.result_kind;
    assign o_task_id     = w_res.task_id;
    assign o_tick_now    = w_res.tick_now;
    assign o_last_of_run = w_res.last_of_run;

    // The engine only takes commands the queue holds.
    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> w_cmd_valid) else $error("command taken from empty queue");

    // A stalled result holds its value.
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(w_res)))
        else $error("waiting result changed");

    // Add results always close their run.
    a_add_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_result_kind != RES_DUE) |-> o_last_of_run)
        else $error("add result not marked last");

endmodule

>>> sim/frequency_phase_tick_scheduler_unit_tb.sv
// Testbench for the frequency/phase tick scheduler: random add, remove and tick traffic.
`timescale 1ns / 100ps

module frequency_phase_tick_scheduler_unit_tb;
    import fpts_pkg::*;

    localparam int unsigned TABLE_DEPTH = 16;
    localparam int unsigned STALL_LIMIT = 20000;

    // Predicted scheduler state and the queue of results it expects.
    class sched_scoreboard;
        logic [15:0] slot_period[TABLE_DEPTH];
        logic [15:0] slot_offset[TABLE_DEPTH];
        logic [15:0] slot_ident[TABLE_DEPTH];
        int unsigned slot_count;
        logic [15:0] ident_next;
        logic [31:0] tick_count;
        t_result pending_results[$];
        int unsigned error_count;

        function void clear();
            slot_count = 0;
            ident_next = 0;
            tick_count = 0;
            pending_results.delete();
            error_count = 0;
        endfunction

        function void emit(logic [1:0] rk, logic [15:0] id);
            t_result r;
            r.result_kind = rk;
            r.task_id = id;
            r.tick_now = tick_count;
            r.last_of_run = 1'b0;
            pending_results = {pending_results, r};
        endfunction

        // Apply one accepted command to the predicted table.
        function void note_command(t_cmd c);
            int unsigned kept;
            int unsigned due_count;
            logic [32:0] phase_sum;
            due_count = 0;
            kept = 0;
            case (c.kind)
                KIND_ADD: begin
                    if (slot_count >= TABLE_DEPTH) begin
                        emit(RES_FULL, 16'd0);
                    end else begin
                        slot_period[slot_count] = c.period;
                        slot_offset[slot_count] = c.offset;
                        slot_ident[slot_count] = ident_next;
                        slot_count++;
                        emit(RES_ADDED, ident_next);
                        ident_next = ident_next + 16'd1;
                    end
                    due_count = 1;
                end
                KIND_REMOVE: begin
                    for (int i = 0; i < slot_count; i++) begin
                        if (slot_ident[i] != c.target_id) begin
                            slot_period[kept] = slot_period[i];
                            slot_offset[kept] = slot_offset[i];
                            slot_ident[kept] = slot_ident[i];
                            kept++;
                        end
                    end
                    slot_count = kept;
                end
                KIND_TICK: begin
                    tick_count = tick_count + 32'd1;
                    for (int i = 0; i < slot_count; i++) begin
                        phase_sum = {1'b0, tick_count} + {17'd0, slot_offset[i]};
                        if (due_count < RESULT_LIMIT && slot_period[i] != 16'd0 &&
                            tick_count >= {16'd0, slot_period[i]} &&
                            (phase_sum % {17'd0, slot_period[i]}) == 33'd0) begin
                            emit(RES_DUE, slot_ident[i]);
                            due_count++;
                        end
                    end
                end
                default: ;
            endcase
            if (due_count > 0)
                pending_results[$].last_of_run = 1'b1;
        endfunction

        function void report(string what, logic [31:0] got, logic [31:0] want);
            $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
            error_count++;
        endfunction

        // Compare one transferred result with the oldest expectation.
        function void check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                report("unexpected result task_id", 32'(got.task_id), 32'd0);
                return;
            end
            want = pending_results.pop_front();
            if (got.result_kind !== want.result_kind)
                report("result_kind", 32'(got.result_kind), 32'(want.result_kind));
            if (got.task_id !== want.task_id)
                report("task_id", 32'(got.task_id), 32'(want.task_id));
            if (got.tick_now !== want.tick_now)
                report("tick_now", got.tick_now, want.tick_now);
            if (got.last_of_run !== want.last_of_run)
                report("last_of_run", 32'(got.last_of_run), 32'(want.last_of_run));
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_push = 1'b0;
    logic i_pop = 1'b0;
    logic [1:0] i_kind = KIND_ADD;
    logic [15:0] i_period = '0;
    logic [15:0] i_offset = '0;
    logic [15:0] i_target_id = '0;
    logic o_full, o_empty, o_last_of_run;
    logic [1:0] o_result_kind;
    logic [15:0] o_task_id;
    logic [31:0] o_tick_now;

    sched_scoreboard board = new();
    int unsigned idle_cycles = 0;
    bit quiet_phase = 1'b0;
    bit stim_done = 1'b0;

    frequency_phase_tick_scheduler_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(i_push), .o_full(o_full),
        .i_kind(i_kind), .i_period(i_period), .i_offset(i_offset),
        .i_target_id(i_target_id), .o_empty(o_empty), .i_pop(i_pop),
        .o_result_kind(o_result_kind), .o_task_id(o_task_id),
        .o_tick_now(o_tick_now), .o_last_of_run(o_last_of_run)
    );

    always #4 i_clk = ~i_clk;

    // Send one command, with a random idle gap before it; push drops only while idling.
    task automatic send_command(logic [1:0] kind, logic [15:0] per, logic [15:0] off,
                                logic [15:0] tid);
        t_cmd c;
        while (!quiet_phase && $urandom_range(99) < 18) begin
            i_push <= 1'b0;
            @(posedge i_clk);
        end
        i_push <= 1'b1;
        i_kind <= kind;
        i_period <= per;
        i_offset <= off;
        i_target_id <= tid;
        do @(posedge i_clk); while (o_full);
        c.kind = kind;
        c.period = per;
        c.offset = off;
        c.target_id = tid;
        board.note_command(c);
    endtask

    // Pick a remove target that is often a live id.
    function automatic logic [15:0] pick_target();
        if (board.slot_count > 0 && $urandom_range(3) != 0)
            return board.slot_ident[$urandom_range(board.slot_count - 1)];
        return 16'($urandom_range(65535));
    endfunction

    // Result side: random pops, checked at the transfer edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_pop && !o_empty)
                board.check_result('{o_result_kind, o_task_id, o_tick_now, o_last_of_run});
            i_pop <= quiet_phase || ($urandom_range(99) >= 18);
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if ((i_push && !o_full) || (i_pop && !o_empty) || !i_rst_n)
            idle_cycles <= 0;
        else if (board.pending_results.size() > 0 || (i_push && !stim_done))
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("frequency_phase_tick_scheduler_unit verification failed");
            $finish;
        end
    end

    initial begin
        int unsigned r;
        board.clear();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, period zero, full table, removes, unused kind.
        send_command(KIND_TICK, 16'd0, 16'd0, 16'd0);
        send_command(KIND_ADD, 16'd0, 16'hFFFF, 16'd0);
        send_command(KIND_ADD, 16'd1, 16'd0, 16'd0);
        send_command(KIND_ADD, 16'hFFFF, 16'hFFFF, 16'd0);
        send_command(KIND_ADD, 16'd2, 16'd1, 16'd0);
        send_command(KIND_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_command(KIND_TICK, 16'd0, 16'd0, 16'd0);
        send_command(KIND_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        for (int i = 0; i < 14; i++)
            send_command(KIND_ADD, 16'd1 + i[15:0], 16'hFFFF - i[15:0], 16'd0);
        send_command(KIND_TICK, 16'd0, 16'd0, 16'd0);
        send_command(KIND_REMOVE, 16'd0, 16'd0, 16'd1);
        send_command(KIND_REMOVE, 16'd0, 16'd0, 16'hFFFF);

        // Random traffic; a quiet stretch in the middle has no idling.
        for (int n = 0; n < 310; n++) begin
            quiet_phase = (n >= 120 && n < 170);
            r = $urandom_range(99);
            if (r < 35)
                send_command(KIND_ADD,
                             ($urandom_range(9) == 0) ? 16'($urandom_range(65535))
                                                      : 16'($urandom_range(12)),
                             16'($urandom_range(65535)), 16'($urandom_range(65535)));
            else if (r < 50)
                send_command(KIND_REMOVE, 16'($urandom_range(65535)),
                             16'($urandom_range(65535)), pick_target());
            else if (r < 97)
                send_command(KIND_TICK, 16'($urandom_range(65535)),
                             16'($urandom_range(65535)), 16'($urandom_range(65535)));
            else
                send_command(KIND_UNUSED, 16'($urandom_range(65535)),
                             16'($urandom_range(65535)), 16'($urandom_range(65535)));
        end
        i_push <= 1'b0;
        stim_done = 1'b1;
        quiet_phase = 1'b0;

        while (board.pending_results.size() > 0)
            @(posedge i_clk);
        repeat (700) @(posedge i_clk);

        if (board.error_count == 0 && board.pending_results.size() == 0)
            $display("frequency_phase_tick_scheduler_unit verification clean");
        else
            $display("frequency_phase_tick_scheduler_unit verification failed");
        $finish;
    end

endmodule
